// ===== sv/nearest_color_pixel_marker_unit_assert.svh =====
// Assertion macros used by the port checker module of this block.
// Both macros sample on i_clk and are disabled while i_rst_n is low, so the
// module that uses them must have ports of those names.
`ifndef NEAREST_COLOR_PIXEL_MARKER_UNIT_ASSERT_SVH
`define NEAREST_COLOR_PIXEL_MARKER_UNIT_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define NCPM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// The expression must never be true outside reset.
`define NCPM_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ===== sv/ncpm_pkg.sv =====
// ----------------------------------------------------------------------------
// ncpm_pkg
// Types, constants and arithmetic helpers of the nearest color pixel marker.
// ----------------------------------------------------------------------------
package ncpm_pkg;

    localparam int NUM_COLORS = 6;
    localparam int PIX_W      = 24;
    localparam int SUM_W      = 20;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int NUM_CELLS  = SUM_W / 2;
    // Sum stage, root cells, select stage.
    localparam int PIPE_LAT   = NUM_CELLS + 2;

    localparam int SEL_W      = 4;
    localparam int THR_W      = 10;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;
    localparam int IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SELECTED_COLOR  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESHOLD = 4'd1;

    localparam logic [SEL_W-1:0] SEL_RESET = 4'd0;
    localparam logic [THR_W-1:0] THR_RESET = 10'd265;
    // Colors at this index and above are never substituted.
    localparam logic [IDX_W-1:0] REPLACE_LIMIT = 3'd5;

    localparam logic [PIX_W-1:0] PALETTE [NUM_COLORS] = '{
        24'hFF0000, 24'h0000FF, 24'h00FF00, 24'hFFFF00, 24'hFF00FF, 24'h00FFFF
    };

    // One lane of the root pipeline: partial remainder, root and radicand bits left.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  rad;
    } t_lane;

    // One beat travelling along the cell chain.
    typedef struct packed {
        logic                         valid;
        logic [PIX_W-1:0]             pixel;
        t_lane [NUM_COLORS-1:0]       lanes;
    } t_beat;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    // Weighted squared distance: 5*dr^2/2 + 3*dg^2/2 + 11*db^2/4, each floored.
    function automatic logic [SUM_W-1:0] color_sum(input logic [PIX_W-1:0] px,
                                                   input logic [PIX_W-1:0] col);
        logic [15:0] sr;
        logic [15:0] sb;
        logic [15:0] sg;
        logic [19:0] tr;
        logic [19:0] tg;
        logic [19:0] tb;
        sr = sq_diff(px[23:16], col[23:16]);
        sb = sq_diff(px[15:8], col[15:8]);
        sg = sq_diff(px[7:0], col[7:0]);
        tr = ({4'd0, sr} << 2) + {4'd0, sr};
        tg = ({4'd0, sg} << 3) + ({4'd0, sg} << 1) + {4'd0, sg};
        tb = ({4'd0, sb} << 1) + {4'd0, sb};
        return (tr >> 1) + (tg >> 2) + (tb >> 1);
    endfunction

endpackage

// ===== sv/nearest_color_pixel_marker_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_color_pixel_marker_unit
// Marks pixels whose nearest palette color is the selected class.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_pixel_in and raise start; a beat is taken at every edge
//   where start is high and busy is low. busy is always low, so one pixel
//   can enter on every clock.
//   Output: o_strobe is high for one cycle with o_pixel_out; the receiver
//   cannot stall and must take every beat.
//   Pipeline: the result beat passes a weighted-sum register, ten root
//   cells each resolving one root bit, and the selection logic with its
//   output register.
//   Throughput: one pixel per clock; the ten-cell root chain sets the depth.
//   Configuration: i_cfg_we with i_cfg_idx writes i_cfg_data to a register;
//   index 0 is the selected color, index 1 the match threshold; other
//   indexes are ignored. Write only while no pixel is in flight.
//   Reset: synchronous, active low; it empties the pipeline, sets the
//   selected color to 0 and the threshold to 265.
// ----------------------------------------------------------------------------
module nearest_color_pixel_marker_unit
    import ncpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_strobe,
    output logic [PIX_W-1:0]      o_pixel_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SEL_W-1:0] r_selected_color;
    logic [THR_W-1:0] r_match_threshold;
    t_beat            r_sum_beat;
    t_beat            n_sum_beat;
    t_beat            cell_beat [NUM_CELLS+1];
    logic             r_strobe;
    logic [PIX_W-1:0] r_pixel_out;
    logic [PIX_W-1:0] n_pixel_out;

    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selected_color  <= SEL_RESET;
            r_match_threshold <= THR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SELECTED_COLOR) begin
                r_selected_color <= i_cfg_data[SEL_W-1:0];
            end else if (i_cfg_idx == CFG_MATCH_THRESHOLD) begin
                r_match_threshold <= i_cfg_data[THR_W-1:0];
            end
        end
    end

    // Weighted squared distances to every palette color.
    always_comb begin
        n_sum_beat.valid = start && !busy;
        n_sum_beat.pixel = i_pixel_in;
        for (int i = 0; i < NUM_COLORS; i++) begin
            n_sum_beat.lanes[i].rem  = '0;
            n_sum_beat.lanes[i].root = '0;
            n_sum_beat.lanes[i].rad  = color_sum(i_pixel_in, PALETTE[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_beat.pixel <= n_sum_beat.pixel;
        r_sum_beat.lanes <= n_sum_beat.lanes;
        if (!i_rst_n) begin
            r_sum_beat.valid <= 1'b0;
        end else begin
            r_sum_beat.valid <= n_sum_beat.valid;
        end
    end

    // Chain of root cells.
    assign cell_beat[0] = r_sum_beat;

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        ncpm_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (cell_beat[c]),
            .o_beat  (cell_beat[c+1])
        );
    end

    // Pick the first strictly smallest root under the threshold.
    always_comb begin
        logic              found;
        logic [ROOT_W-1:0] best;
        logic [IDX_W-1:0]  best_idx;
        logic [ROOT_W-1:0] d;
        found    = 1'b0;
        best     = '0;
        best_idx = '0;
        for (int i = 0; i < NUM_COLORS; i++) begin
            d = cell_beat[NUM_CELLS].lanes[i].root;
            if (d < r_match_threshold && (!found || d < best)) begin
                found    = 1'b1;
                best     = d;
                best_idx = IDX_W'(i);
            end
        end
        n_pixel_out = cell_beat[NUM_CELLS].pixel;
        if (found && best_idx < REPLACE_LIMIT
            && r_selected_color == ({1'b0, best_idx} + 4'd1)) begin
            n_pixel_out = PALETTE[best_idx];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_pixel_out <= n_pixel_out;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= cell_beat[NUM_CELLS].valid;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_pixel_out = r_pixel_out;

endmodule

// ===== sv/ncpm_root_cell.sv =====
// ----------------------------------------------------------------------------
// ncpm_root_cell
// One digit step of the integer square root for every palette lane.
// ----------------------------------------------------------------------------
module ncpm_root_cell
    import ncpm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_beat i_beat,
    output t_beat o_beat
);

    t_beat r_beat;
    t_beat n_beat;

    // Bring down two radicand bits and try to extend the root by a one.
    always_comb begin
        logic [REM_W+1:0] cand;
        logic [REM_W+1:0] trial;
        n_beat = i_beat;
        for (int i = 0; i < NUM_COLORS; i++) begin
            cand  = {i_beat.lanes[i].rem, i_beat.lanes[i].rad[SUM_W-1 -: 2]};
            trial = {2'b00, i_beat.lanes[i].root, 2'b01};
            n_beat.lanes[i].rad = {i_beat.lanes[i].rad[SUM_W-3:0], 2'b00};
            if (cand >= trial) begin
                n_beat.lanes[i].rem  = REM_W'(cand - trial);
                n_beat.lanes[i].root = {i_beat.lanes[i].root[ROOT_W-2:0], 1'b1};
            end else begin
                n_beat.lanes[i].rem  = REM_W'(cand);
                n_beat.lanes[i].root = {i_beat.lanes[i].root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Hand the beat to the next cell; only the valid flag needs reset.
    always_ff @(posedge i_clk) begin
        r_beat.pixel <= n_beat.pixel;
        r_beat.lanes <= n_beat.lanes;
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== sv/ncpm_checker.sv =====
// ----------------------------------------------------------------------------
// ncpm_port_checks
// Port-level checks of the nearest color pixel marker, bound to the top level.
// ----------------------------------------------------------------------------
`include "nearest_color_pixel_marker_unit_assert.svh"

module ncpm_port_checks
    import ncpm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [PIX_W-1:0] i_pixel_in,
    input logic             o_strobe,
    input logic [PIX_W-1:0] o_pixel_out
);

    logic pal_hit;

    // The result equals one of the replaceable palette colors.
    assign pal_hit = o_pixel_out == PALETTE[0] || o_pixel_out == PALETTE[1]
                     || o_pixel_out == PALETTE[2] || o_pixel_out == PALETTE[3]
                     || o_pixel_out == PALETTE[4];

    // The block never refuses a beat.
    `NCPM_ASSERT_NEVER(a_never_busy, busy)

    // Every result beat traces back to an accepted beat one latency ago.
    `NCPM_ASSERT_IMPLY(a_strobe_has_source, o_strobe, $past(start, PIPE_LAT))

    // A result is the pixel itself or one of the replaceable palette colors.
    `NCPM_ASSERT_IMPLY(a_result, o_strobe, pal_hit || o_pixel_out == $past(i_pixel_in, PIPE_LAT))

endmodule

bind nearest_color_pixel_marker_unit ncpm_port_checks u_ncpm_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_pixel_in  (i_pixel_in),
    .o_strobe    (o_strobe),
    .o_pixel_out (o_pixel_out)
);

// ===== verif/ncpm_checker.sv =====
// ----------------------------------------------------------------------------
// ncpm_checker
// Watches the pixel, result and configuration ports of the marker, predicts
// each output pixel from the accepted input and the current register values,
// and compares the result beats in order against the predictions.
// ----------------------------------------------------------------------------
module ncpm_checker
    import ncpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_strobe,
    input  logic [PIX_W-1:0]      i_pixel_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PIX_W-1:0] COLORS [NUM_COLORS] = '{
        24'hFF0000, 24'h0000FF, 24'h00FF00, 24'hFFFF00, 24'hFF00FF, 24'h00FFFF
    };

    logic [SEL_W-1:0] sel_color;
    logic [THR_W-1:0] threshold;
    logic [PIX_W-1:0] expected_pixels [$];

    // Absolute difference of one channel, squared.
    function automatic int unsigned chan_sq(input logic [7:0] a, input logic [7:0] b);
        int unsigned d;
        d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        return d * d;
    endfunction

    // Floor square root by search over the result bits.
    function automatic int unsigned floor_root(input int unsigned v);
        int unsigned r;
        r = 0;
        for (int b = 10; b >= 0; b--) begin
            if ((r | (1 << b)) * (r | (1 << b)) <= v)
                r = r | (1 << b);
        end
        return r;
    endfunction

    // Predicted output pixel for one input pixel.
    function automatic logic [PIX_W-1:0] marked_pixel(input logic [PIX_W-1:0] px);
        int unsigned root_dist;
        int unsigned best;
        int          best_idx;
        logic [PIX_W-1:0] c;
        best_idx = -1;
        best = 0;
        for (int i = 0; i < NUM_COLORS; i++) begin
            c = COLORS[i];
            root_dist = floor_root((5 * chan_sq(px[23:16], c[23:16])) / 2
                                 + (11 * chan_sq(px[7:0], c[7:0])) / 4
                                 + (3 * chan_sq(px[15:8], c[15:8])) / 2);
            if (root_dist < threshold && (best_idx < 0 || root_dist < best)) begin
                best = root_dist;
                best_idx = i;
            end
        end
        if (best_idx >= 0 && best_idx < 5 && int'(sel_color) == best_idx + 1)
            return COLORS[best_idx];
        return px;
    endfunction

    assign o_pending = expected_pixels.size();

    // Track registers, record predictions and check result beats.
    always @(posedge i_clk) begin
        logic [PIX_W-1:0] exp_px;
        if (!i_rst_n) begin
            sel_color <= SEL_RESET;
            threshold <= THR_RESET;
            expected_pixels.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_start && !i_busy)
                expected_pixels.push_back(marked_pixel(i_pixel_in));
            if (i_strobe) begin
                o_results <= o_results + 1;
                if (expected_pixels.size() == 0) begin
                    if (o_errors < 10)
                        $display("Unexpected result beat: pixel_out=%06h", i_pixel_out);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_px = expected_pixels.pop_front();
                    if (exp_px !== i_pixel_out) begin
                        if (o_errors < 10)
                            $display("Mismatch pixel_out: expected %06h, got %06h",
                                     exp_px, i_pixel_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SELECTED_COLOR)
                    sel_color <= i_cfg_data[SEL_W-1:0];
                else if (i_cfg_idx == CFG_MATCH_THRESHOLD)
                    threshold <= i_cfg_data[THR_W-1:0];
            end
        end
    end
endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the marker with directed and random pixels under several register
// settings and sender idle patterns; the checker judges each result beat.
// ----------------------------------------------------------------------------
module tb_top;
    import ncpm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  o_strobe;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    errors;
    int                    pending;
    int                    results;
    int                    cycles = 0;
    int                    idle_pct;

    always #1 i_clk = ~i_clk;

    nearest_color_pixel_marker_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel_in(i_pixel_in), .o_strobe(o_strobe), .o_pixel_out(o_pixel_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    ncpm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_pixel_in(i_pixel_in), .i_strobe(o_strobe), .i_pixel_out(o_pixel_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one pixel beat, idling first at the current rate.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_pixel_in <= px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drain the pipeline, then write one register.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A pixel near a palette color, or fully random.
    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] px;
        if ($urandom_range(3) == 0)
            return PIX_W'($urandom());
        base = PALETTE[$urandom_range(NUM_COLORS - 1)];
        px = base;
        for (int ch = 0; ch < 3; ch++)
            px[ch*8 +: 8] = base[ch*8 +: 8] ? 8'd255 - 8'($urandom_range(120))
                                            : 8'($urandom_range(120));
        return px;
    endfunction

    initial begin
        int unsigned sel_vals [7] = '{1, 2, 3, 4, 5, 6, 0};
        int unsigned thr_vals [7] = '{265, 1023, 80, 0, 500, 1, 265};
        int          pct_vals [4] = '{0, 69, 0, 20};
        idle_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, each palette color, ties and out-of-range index.
        foreach (PALETTE[i]) send_pixel(PALETTE[i]);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h808080);
        send_pixel(24'h7F7F7F);
        send_pixel(24'h800080);
        write_reg(CFG_SELECTED_COLOR, 1);
        foreach (PALETTE[i]) send_pixel(PALETTE[i]);
        send_pixel(24'hF01010);
        send_pixel(24'h000000);
        write_reg(4'd7, 5);
        send_pixel(24'hFF0000);
        write_reg(CFG_SELECTED_COLOR, 15);
        send_pixel(24'hFF0000);
        send_pixel(24'hAAAAAA);

        // Random phases across register settings and idle rates.
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(CFG_SELECTED_COLOR, sel_vals[ph]);
            write_reg(CFG_MATCH_THRESHOLD, thr_vals[ph]);
            for (int n = 0; n < 150; n++) begin
                idle_pct = pct_vals[(ph + n / 75) % 4];
                send_pixel(rand_pixel());
            end
        end
        start <= 1'b0;
        idle_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);

        $display("Checked %0d result beats over seven register settings,", results);
        $display("with directed extremes, palette colors and sender idle patterns.");
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
